>>> rtl/ssid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssid_pkg - scalar shift-by-immediate decoder package
// Operation numbers, decode classes, result record and U:opcode lookup.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OP_W    = 5;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned SIZE_W  = 2;
  localparam int unsigned SHIFT_W = 7;

  typedef enum logic [4:0] {
    OP_SSHR     = 5'd0,
    OP_SSRA     = 5'd1,
    OP_SRSHR    = 5'd2,
    OP_SRSRA    = 5'd3,
    OP_SHL      = 5'd4,
    OP_SQSHL    = 5'd5,
    OP_SQSHRN   = 5'd6,
    OP_SQRSHRN  = 5'd7,
    OP_SCVTF    = 5'd8,
    OP_FCVTZS   = 5'd9,
    OP_USHR     = 5'd10,
    OP_USRA     = 5'd11,
    OP_URSHR    = 5'd12,
    OP_URSRA    = 5'd13,
    OP_SRI      = 5'd14,
    OP_SLI      = 5'd15,
    OP_SQSHLU   = 5'd16,
    OP_UQSHL    = 5'd17,
    OP_SQSHRUN  = 5'd18,
    OP_SQRSHRUN = 5'd19,
    OP_UQSHRN   = 5'd20,
    OP_UQRSHRN  = 5'd21,
    OP_UCVTF    = 5'd22,
    OP_FCVTZU   = 5'd23
  } op_t;

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_RIGHT64 = 3'd1,
    CLS_LEFT64  = 3'd2,
    CLS_LEFTANY = 3'd3,
    CLS_NARROW  = 3'd4,
    CLS_CONV    = 3'd5
  } cls_t;

  typedef struct packed {
    op_t  op;
    cls_t cls;
  } entry_t;

  typedef struct packed {
    logic                 valid_res;
    logic [OP_W-1:0]      op_id;
    logic [REG_W-1:0]     dest_reg;
    logic [REG_W-1:0]     src_reg;
    logic [SIZE_W-1:0]    dest_size;
    logic [SIZE_W-1:0]    src_size;
    logic [SHIFT_W-1:0]   shift_amount;
  } res_t;

  // Lookup indexed by U:opcode.
  function automatic entry_t lookup(input logic [5:0] enc);
    entry_t e;
    e = '{op: OP_SSHR, cls: CLS_NONE};
    case (enc)
      6'h00: e = '{op: OP_SSHR,     cls: CLS_RIGHT64};
      6'h02: e = '{op: OP_SSRA,     cls: CLS_RIGHT64};
      6'h04: e = '{op: OP_SRSHR,    cls: CLS_RIGHT64};
      6'h06: e = '{op: OP_SRSRA,    cls: CLS_RIGHT64};
      6'h0A: e = '{op: OP_SHL,      cls: CLS_LEFT64};
      6'h0E: e = '{op: OP_SQSHL,    cls: CLS_LEFTANY};
      6'h12: e = '{op: OP_SQSHRN,   cls: CLS_NARROW};
      6'h13: e = '{op: OP_SQRSHRN,  cls: CLS_NARROW};
      6'h1C: e = '{op: OP_SCVTF,    cls: CLS_CONV};
      6'h1F: e = '{op: OP_FCVTZS,   cls: CLS_CONV};
      6'h20: e = '{op: OP_USHR,     cls: CLS_RIGHT64};
      6'h22: e = '{op: OP_USRA,     cls: CLS_RIGHT64};
      6'h24: e = '{op: OP_URSHR,    cls: CLS_RIGHT64};
      6'h26: e = '{op: OP_URSRA,    cls: CLS_RIGHT64};
      6'h28: e = '{op: OP_SRI,      cls: CLS_RIGHT64};
      6'h2A: e = '{op: OP_SLI,      cls: CLS_LEFT64};
      6'h2C: e = '{op: OP_SQSHLU,   cls: CLS_LEFTANY};
      6'h2E: e = '{op: OP_UQSHL,    cls: CLS_LEFTANY};
      6'h30: e = '{op: OP_SQSHRUN,  cls: CLS_NARROW};
      6'h31: e = '{op: OP_SQRSHRUN, cls: CLS_NARROW};
      6'h32: e = '{op: OP_UQSHRN,   cls: CLS_NARROW};
      6'h33: e = '{op: OP_UQRSHRN,  cls: CLS_NARROW};
      6'h3C: e = '{op: OP_UCVTF,    cls: CLS_CONV};
      6'h3F: e = '{op: OP_FCVTZU,   cls: CLS_CONV};
      default: e = '{op: OP_SSHR, cls: CLS_NONE};
    endcase
    return e;
  endfunction

endpackage : ssid_pkg
`default_nettype wire

>>> rtl/simd_scalar_shift_imm_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simd_scalar_shift_imm_decoder_unit - scalar shift-by-immediate decoder
// Decodes one instruction word per cycle, while results are taken, into
// operation, registers, sizes and shift amount via input and result registers.
//
//   channel | ports                       | direction
//   --------+-----------------------------+----------
//   input   | in_valid/in_ready, word     | in
//   result  | out_valid/out_ready, fields | out
//
// One word per cycle sustained while out_ready stays high; an accepted word
// passes through the input register, then is decoded into the result
// register, where out_valid marks it.
// Reset clears both stage valid flags; payload registers are not reset.
// A stalled result holds its register; the input register still takes a
// word if it is empty or its own contents can move forward in the same cycle.
// ----------------------------------------------------------------------------
module simd_scalar_shift_imm_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [ssid_pkg::WORD_W-1:0]   in_insn_word,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_valid_res,
  output      logic [ssid_pkg::OP_W-1:0]     out_op_id,
  output      logic [ssid_pkg::REG_W-1:0]    out_dest_reg,
  output      logic [ssid_pkg::REG_W-1:0]    out_src_reg,
  output      logic [ssid_pkg::SIZE_W-1:0]   out_dest_size,
  output      logic [ssid_pkg::SIZE_W-1:0]   out_src_size,
  output      logic [ssid_pkg::SHIFT_W-1:0]  out_shift_amount
);
  import ssid_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0] s1_word_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r;
  res_t              dec_res;
  logic              s2_ready;
  logic              s1_load;
  logic              s2_load;

  ssid_decode u_decode (
    .word (s1_word_r),
    .res  (dec_res)
  );

  assign s2_ready = ~out_valid_r | out_ready;
  assign in_ready = ~s1_valid_r | s2_ready;
  assign s1_load  = in_valid & in_ready;
  assign s2_load  = s1_valid_r & s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_insn_word;
    end
    if (s2_load) begin
      res_r <= dec_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = res_r.valid_res;
  assign out_op_id        = res_r.op_id;
  assign out_dest_reg     = res_r.dest_reg;
  assign out_src_reg      = res_r.src_reg;
  assign out_dest_size    = res_r.dest_size;
  assign out_src_size     = res_r.src_size;
  assign out_shift_amount = res_r.shift_amount;

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.valid_res) |-> (res_r == '0))
    else $error("reserved encoding with nonzero fields");

  a_src_size : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.valid_res) |->
      (res_r.src_size == res_r.dest_size ||
       res_r.src_size == res_r.dest_size + 2'd1))
    else $error("source size neither equal nor double");

  a_shift_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.valid_res) |-> (res_r.shift_amount <= 7'd64))
    else $error("shift amount out of range");

  a_move : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("decoded word lost between stages");

endmodule : simd_scalar_shift_imm_decoder_unit
`default_nettype wire

>>> rtl/ssid_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssid_decode - field decode for one instruction word
// Splits the word, looks up the operation and forms sizes and shift amount.
// ----------------------------------------------------------------------------
module ssid_decode (
  input  wire logic [ssid_pkg::WORD_W-1:0] word,
  output ssid_pkg::res_t                   res
);
  import ssid_pkg::*;

  logic       u;
  logic [3:0] immh;
  logic [6:0] immhb;
  logic [1:0] hb;
  logic [6:0] esize;
  logic [7:0] esize2;
  logic [7:0] sh_full;
  logic       ok;
  logic [1:0] ssz;
  entry_t     ent;

  assign u      = word[29];
  assign immh   = word[22:19];
  assign immhb  = word[22:16];
  assign ent    = lookup({u, word[15:11]});
  assign esize  = 7'd8 << hb;
  assign esize2 = {esize, 1'b0};

  always_comb begin
    if (immh[3]) begin
      hb = 2'd3;
    end else if (immh[2]) begin
      hb = 2'd2;
    end else if (immh[1]) begin
      hb = 2'd1;
    end else begin
      hb = 2'd0;
    end
  end

  always_comb begin
    ok      = (immh != 4'd0);
    ssz     = hb;
    sh_full = 8'd0;
    case (ent.cls)
      CLS_RIGHT64: begin
        ok      = ok & immh[3];
        sh_full = 8'd128 - {1'b0, immhb};
      end
      CLS_LEFT64: begin
        ok      = ok & immh[3];
        sh_full = {1'b0, immhb} - 8'd64;
      end
      CLS_LEFTANY: begin
        sh_full = {1'b0, immhb} - {1'b0, esize};
      end
      CLS_NARROW: begin
        ok      = ok & ~immh[3];
        ssz     = hb + 2'd1;
        sh_full = esize2 - {1'b0, immhb};
      end
      CLS_CONV: begin
        ok      = ok & (immh != 4'd1);
        sh_full = esize2 - {1'b0, immhb};
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Zero every field of a reserved encoding.
  always_comb begin
    res = '0;
    if (ok) begin
      res.valid_res    = 1'b1;
      res.op_id        = ent.op;
      res.dest_reg     = word[4:0];
      res.src_reg      = word[9:5];
      res.dest_size    = hb;
      res.src_size     = ssz;
      res.shift_amount = sh_full[SHIFT_W-1:0];
    end
  end

endmodule : ssid_decode
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - scalar shift-by-immediate decoder check
// Streams instruction words into the decoder through a bursty driver and
// drains the decoded results through a receiver that stalls on a pattern.
// An in-bench decoder predicts each result, and the monitor compares every
// field in order.
// ----------------------------------------------------------------------------
module testbench;
  import ssid_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1950;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [WORD_W-1:0]   in_insn_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_valid_res;
  logic [OP_W-1:0]     out_op_id;
  logic [REG_W-1:0]    out_dest_reg;
  logic [REG_W-1:0]    out_src_reg;
  logic [SIZE_W-1:0]   out_dest_size;
  logic [SIZE_W-1:0]   out_src_size;
  logic [SHIFT_W-1:0]  out_shift_amount;

  logic [WORD_W-1:0] pending_words[$];
  res_t              decoded_expect[$];
  int unsigned       accepted_count = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left = 0;
  int unsigned       gap_left = 0;
  logic [15:0]       stall_pattern = 16'hFFFF;
  int unsigned       stall_phase = 0;

  simd_scalar_shift_imm_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_insn_word     (in_insn_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_op_id        (out_op_id),
    .out_dest_reg     (out_dest_reg),
    .out_src_reg      (out_src_reg),
    .out_dest_size    (out_dest_size),
    .out_src_size     (out_src_size),
    .out_shift_amount (out_shift_amount)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // U:opcode table: operation and shift class.
  function automatic cls_t opcode_class(input logic [5:0] enc, output op_t op);
    cls_t cls;
    op  = OP_SSHR;
    cls = CLS_NONE;
    case (enc)
      6'h00: begin op = OP_SSHR;     cls = CLS_RIGHT64; end
      6'h02: begin op = OP_SSRA;     cls = CLS_RIGHT64; end
      6'h04: begin op = OP_SRSHR;    cls = CLS_RIGHT64; end
      6'h06: begin op = OP_SRSRA;    cls = CLS_RIGHT64; end
      6'h0A: begin op = OP_SHL;      cls = CLS_LEFT64;  end
      6'h0E: begin op = OP_SQSHL;    cls = CLS_LEFTANY; end
      6'h12: begin op = OP_SQSHRN;   cls = CLS_NARROW;  end
      6'h13: begin op = OP_SQRSHRN;  cls = CLS_NARROW;  end
      6'h1C: begin op = OP_SCVTF;    cls = CLS_CONV;    end
      6'h1F: begin op = OP_FCVTZS;   cls = CLS_CONV;    end
      6'h20: begin op = OP_USHR;     cls = CLS_RIGHT64; end
      6'h22: begin op = OP_USRA;     cls = CLS_RIGHT64; end
      6'h24: begin op = OP_URSHR;    cls = CLS_RIGHT64; end
      6'h26: begin op = OP_URSRA;    cls = CLS_RIGHT64; end
      6'h28: begin op = OP_SRI;      cls = CLS_RIGHT64; end
      6'h2A: begin op = OP_SLI;      cls = CLS_LEFT64;  end
      6'h2C: begin op = OP_SQSHLU;   cls = CLS_LEFTANY; end
      6'h2E: begin op = OP_UQSHL;    cls = CLS_LEFTANY; end
      6'h30: begin op = OP_SQSHRUN;  cls = CLS_NARROW;  end
      6'h31: begin op = OP_SQRSHRUN; cls = CLS_NARROW;  end
      6'h32: begin op = OP_UQSHRN;   cls = CLS_NARROW;  end
      6'h33: begin op = OP_UQRSHRN;  cls = CLS_NARROW;  end
      6'h3C: begin op = OP_UCVTF;    cls = CLS_CONV;    end
      6'h3F: begin op = OP_FCVTZU;   cls = CLS_CONV;    end
      default: ;
    endcase
    return cls;
  endfunction

  function automatic res_t decode_word(input logic [WORD_W-1:0] w);
    res_t       r;
    op_t        op;
    cls_t       cls;
    logic [3:0] immh;
    logic [6:0] immhb;
    int         hb;
    int         esize;
    int         sh;
    logic       ok;
    immh  = w[22:19];
    immhb = {immh, w[18:16]};
    hb    = immh[3] ? 3 : immh[2] ? 2 : immh[1] ? 1 : 0;
    esize = 8 << hb;
    cls   = opcode_class({w[29], w[15:11]}, op);
    ok    = (immh != 4'd0) && (cls != CLS_NONE);
    sh    = 0;
    r     = '0;
    r.dest_size = hb[1:0];
    r.src_size  = hb[1:0];
    case (cls)
      CLS_RIGHT64: begin
        ok = ok && immh[3];
        sh = 128 - immhb;
      end
      CLS_LEFT64: begin
        ok = ok && immh[3];
        sh = immhb - 64;
      end
      CLS_LEFTANY: sh = immhb - esize;
      CLS_NARROW: begin
        ok = ok && !immh[3];
        r.src_size = hb[1:0] + 2'd1;
        sh = 2 * esize - immhb;
      end
      CLS_CONV: begin
        ok = ok && (immh != 4'b0001);
        sh = 2 * esize - immhb;
      end
      default: ;
    endcase
    if (!ok) return '0;
    r.valid_res    = 1'b1;
    r.op_id        = op;
    r.dest_reg     = w[4:0];
    r.src_reg      = w[9:5];
    r.shift_amount = sh[6:0];
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] build_word(input logic [WORD_W-1:0] filler,
                                                   input logic [5:0] enc,
                                                   input logic [3:0] immh,
                                                   input logic [2:0] immb,
                                                   input logic [4:0] rn,
                                                   input logic [4:0] rd);
    logic [WORD_W-1:0] w;
    w = filler;
    w[29]    = enc[5];
    w[22:19] = immh;
    w[18:16] = immb;
    w[15:11] = enc[4:0];
    w[9:5]   = rn;
    w[4:0]   = rd;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got,
                             input logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Driver: bursts of words with random gaps; hold a word until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        decoded_expect.push_back(decode_word(in_insn_word));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_insn_word <= pending_words.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotate through a stall pattern, pick a fresh one now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_phase % 256 == 0) begin
        if ($urandom_range(0, 3) == 0) stall_pattern = 16'hFFFF;
        else stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
      end
      out_ready <= stall_pattern[stall_phase % 16];
      stall_phase++;
    end
  end

  // Monitor: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_expect.size() == 0) begin
        report_mismatch("result with no word outstanding");
      end else begin
        want = decoded_expect.pop_front();
        check_field("valid_res", 7'(out_valid_res), 7'(want.valid_res));
        check_field("op_id", 7'(out_op_id), 7'(want.op_id));
        check_field("dest_reg", 7'(out_dest_reg), 7'(want.dest_reg));
        check_field("src_reg", 7'(out_src_reg), 7'(want.src_reg));
        check_field("dest_size", 7'(out_dest_size), 7'(want.dest_size));
        check_field("src_size", 7'(out_src_size), 7'(want.src_size));
        check_field("shift_amount", out_shift_amount, want.shift_amount);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned   total;
    int unsigned   n;
    logic [5:0]    enc;
    logic [3:0]    immh;
    op_t           op;
    cls_t          cls;
    logic          hi;
    // Every allocated operation at a legal size, extremes of immb and regs.
    n = 0;
    for (int e = 0; e < 64; e++) begin
      enc = e[5:0];
      cls = opcode_class(enc, op);
      if (cls != CLS_NONE) begin
        hi = n[0];
        case (cls)
          CLS_RIGHT64, CLS_LEFT64: immh = hi ? 4'hF : 4'h8;
          CLS_NARROW:              immh = hi ? 4'h7 : 4'h1;
          CLS_CONV:                immh = hi ? 4'hF : 4'h2;
          default:                 immh = hi ? 4'hF : 4'h1;
        endcase
        pending_words.push_back(build_word(hi ? '1 : '0, enc, immh, hi ? 3'd7 : 3'd0,
                                           hi ? 5'd31 : 5'd0, hi ? 5'd0 : 5'd31));
        n++;
      end
    end
    pending_words.push_back('0);
    pending_words.push_back('1);
    // Unallocated opcode, short right shift, wide narrow, byte conversion.
    pending_words.push_back(build_word('0, 6'h01, 4'h8, 3'd3, 5'd5, 5'd9));
    pending_words.push_back(build_word('1, 6'h00, 4'h7, 3'd7, 5'd1, 5'd2));
    pending_words.push_back(build_word('0, 6'h12, 4'h8, 3'd0, 5'd3, 5'd4));
    pending_words.push_back(build_word('1, 6'h1C, 4'h1, 3'd5, 5'd6, 5'd7));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_words.push_back($urandom());
      end else begin
        do enc = 6'($urandom_range(0, 63)); while (opcode_class(enc, op) == CLS_NONE);
        immh = ($urandom_range(0, 9) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
        pending_words.push_back(build_word($urandom(), enc, immh, 3'($urandom_range(0, 7)),
                                           5'($urandom_range(0, 31)),
                                           5'($urandom_range(0, 31))));
      end
    end
    total = pending_words.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total) @(posedge clk);
    while (decoded_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
